// ----- design/iafp_pkg.sv -----
// iafp_pkg: shared types, constants and helpers of the imu angle frame parser
// no dependencies; imported by every other file of the block

package iafp_pkg;

  // frame layout
  localparam int unsigned FRAME_LAST_INDEX = 10;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ANGLE_BYTES = 6;
  localparam int unsigned SLOT_W = $clog2(ANGLE_BYTES);
  localparam logic [INDEX_W-1:0] IDX_HEADER_FIRST = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] IDX_HEADER_SECOND = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] IDX_ANGLE_FIRST = INDEX_W'(2);
  localparam logic [INDEX_W-1:0] IDX_ANGLE_LAST = INDEX_W'(7);
  localparam logic [INDEX_W-1:0] IDX_FRAME_LAST = INDEX_W'(FRAME_LAST_INDEX);

  // configuration port
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = CFG_INDEX_W'(1);
  localparam logic [CFG_DATA_W-1:0] HEADER_FIRST_RESET = 8'h55;
  localparam logic [CFG_DATA_W-1:0] HEADER_SECOND_RESET = 8'h53;

  // angle scaling: raw/32768*180*128 == raw*45/64
  localparam int unsigned RAW_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SCALE_SHIFT = 6;
  localparam int unsigned PROD_W = RAW_W + SCALE_SHIFT;
  localparam logic [PROD_W-1:0] ANGLE_SCALE = PROD_W'(45);

  // frame queue between parser and scaler
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             checksum_ok;
    logic [RAW_W-1:0] pitch_raw;
    logic [RAW_W-1:0] roll_raw;
    logic [RAW_W-1:0] yaw_raw;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [ANGLE_W-1:0] to_angle(input logic [RAW_W-1:0] raw);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(raw) * ANGLE_SCALE;
    return prod[PROD_W-1:SCALE_SHIFT];
  endfunction

endpackage

// ----- design/iafp_if.sv -----
// iafp_if: valid/ready channel interfaces for received bytes and angle results
// depends on iafp_pkg for field widths

interface iafp_byte_if import iafp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface iafp_result_if import iafp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               checksum_ok;
  logic [ANGLE_W-1:0] pitch_deg;
  logic [ANGLE_W-1:0] roll_deg;
  logic [ANGLE_W-1:0] yaw_deg;

  modport source (output valid, output checksum_ok, output pitch_deg, output roll_deg,
                  output yaw_deg, input ready);
  modport sink (input valid, input checksum_ok, input pitch_deg, input roll_deg,
                input yaw_deg, output ready);
endinterface

// ----- design/iafp_front.sv -----
// iafp_front: header registers and byte-by-byte frame parser with running checksum
// depends on iafp_pkg and iafp_byte_if; pushes one frame record per completed frame

module iafp_front import iafp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  iafp_byte_if.sink              byte_in,
  output logic                   push,
  output frame_t                 push_frame,
  input  logic                   queue_full
);

  logic [CFG_DATA_W-1:0] header_first;
  logic [CFG_DATA_W-1:0] header_second;
  logic [INDEX_W-1:0]    byte_index;
  logic [INDEX_W-1:0]    byte_index_next;
  logic [7:0]            running_sum;
  logic [7:0]            running_sum_next;
  logic [7:0]            angle_bytes [ANGLE_BYTES];
  logic [SLOT_W-1:0]     slot;
  logic                  at_last;
  logic                  accept;
  logic                  sum_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RESET;
      header_second <= HEADER_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first <= cfg_wdata;
        REG_HEADER_SECOND: header_second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // indexes past the end count as the checksum byte
  assign at_last = byte_index >= IDX_FRAME_LAST;
  assign byte_in.ready = !at_last || !queue_full;
  assign accept = byte_in.valid && byte_in.ready;
  assign slot = SLOT_W'(byte_index - IDX_ANGLE_FIRST);
  assign sum_match = running_sum == byte_in.rx_byte;

  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    if (byte_index == IDX_HEADER_FIRST) begin
      if (byte_in.rx_byte == header_first) begin
        running_sum_next = byte_in.rx_byte;
        byte_index_next  = IDX_HEADER_SECOND;
      end else begin
        byte_index_next = IDX_HEADER_FIRST;
      end
    end else if (byte_index == IDX_HEADER_SECOND) begin
      if (byte_in.rx_byte == header_second) begin
        running_sum_next = running_sum + byte_in.rx_byte;
        byte_index_next  = IDX_ANGLE_FIRST;
      end else begin
        byte_index_next = IDX_HEADER_FIRST;
      end
    end else if (!at_last) begin
      running_sum_next = running_sum + byte_in.rx_byte;
      byte_index_next  = byte_index + INDEX_W'(1);
    end else begin
      running_sum_next = '0;
      byte_index_next  = IDX_HEADER_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (byte_index inside {[IDX_ANGLE_FIRST:IDX_ANGLE_LAST]})) begin
      for (int i = 0; i < ANGLE_BYTES; i++) begin
        if (slot == SLOT_W'(i)) begin
          angle_bytes[i] <= byte_in.rx_byte;
        end
      end
    end
  end

  // bad checksum carries zero raw words, which scale to zero angles
  assign push = accept && at_last;
  always_comb begin
    push_frame.checksum_ok = sum_match;
    push_frame.pitch_raw   = sum_match ? {angle_bytes[1], angle_bytes[0]} : '0;
    push_frame.roll_raw    = sum_match ? {angle_bytes[3], angle_bytes[2]} : '0;
    push_frame.yaw_raw     = sum_match ? {angle_bytes[5], angle_bytes[4]} : '0;
  end

endmodule

// ----- design/iafp_queue.sv -----
// iafp_queue: short frame record queue between parser and scaler
// depends on iafp_pkg for frame_t and the queue depth

module iafp_queue import iafp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_t        push_frame,
  input  logic          pop,
  output frame_t        pop_frame,
  output queue_status_t status
);

  frame_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign pop_frame    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- design/iafp_back.sv -----
// iafp_back: scales raw angle words to 1/128 degree and holds the result register
// depends on iafp_pkg (to_angle) and iafp_result_if

module iafp_back import iafp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  frame_t        pop_frame,
  input  logic          queue_empty,
  output logic          pop,
  iafp_result_if.source result_out
);

  logic out_valid;

  assign pop = !queue_empty && (!out_valid || result_out.ready);
  assign result_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_out.checksum_ok <= pop_frame.checksum_ok;
      result_out.pitch_deg   <= to_angle(pop_frame.pitch_raw);
      result_out.roll_deg    <= to_angle(pop_frame.roll_raw);
      result_out.yaw_deg     <= to_angle(pop_frame.yaw_raw);
    end
  end

endmodule

// ----- design/imu_angle_frame_parser_unit.sv -----
// imu_angle_frame_parser_unit: top level of the imu angle frame parser
// depends on iafp_pkg, iafp_if, iafp_front, iafp_queue and iafp_back
//
// Takes one received serial byte per beat and assembles 11-byte angle frames:
// two header bytes (header_first, header_second; reset 0x55 and 0x53), six
// angle bytes (pitch, roll, yaw as little-endian 16-bit words), two ignored
// bytes and a checksum byte equal to the 8-bit sum of the ten before it. A
// wrong header byte restarts the search at the next byte. Each completed frame
// gives one result beat: checksum_ok and the three angles in 1/128 degree,
// (raw*45)>>6; a checksum error gives zero angles. A byte beat is taken every
// cycle unless stalled; a frame result passes the two-entry frame queue and
// then the output register. The parser stalls only on a checksum byte while
// the queue is full, so a stalled result sink blocks input after two further
// completed frames. Header registers are written by the user through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.

module imu_angle_frame_parser_unit import iafp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  iafp_byte_if.sink              byte_in,
  iafp_result_if.source          result_out
);

  // parser to queue
  logic          push;
  frame_t        push_frame;
  // queue to scaler
  logic          pop;
  frame_t        pop_frame;
  queue_status_t queue_status;

  // front: header match, byte index, running sum, angle byte capture
  iafp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_in    (byte_in),
    .push       (push),
    .push_frame (push_frame),
    .queue_full (queue_status.full)
  );

  // decouples the parser from a stalled result sink
  iafp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (queue_status)
  );

  // back: constant scaling into the registered result beat
  iafp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_frame   (pop_frame),
    .queue_empty (queue_status.empty),
    .pop         (pop),
    .result_out  (result_out)
  );

`ifndef NO_ASSERTIONS
  // no frame record goes into a full queue unless one leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_status.full || pop)
    else $error("frame queue overflow");

  // the scaler never takes a record from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_status.empty)
    else $error("frame queue underflow");

  // a failed checksum always reports zero angles
  a_bad_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.checksum_ok) |->
      (result_out.pitch_deg == '0 && result_out.roll_deg == '0 &&
       result_out.yaw_deg == '0))
    else $error("nonzero angle on checksum error");

  // a popped record shows up as a result beat in the next cycle
  a_pop_to_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> result_out.valid)
    else $error("popped frame lost");
`endif

endmodule

// ----- test/imu_angle_frame_parser_unit_tb.sv -----
// imu_angle_frame_parser_unit_tb: self-checking bench for the imu angle frame parser
// drives byte beats and header writes, predicts each frame result and checks it field by field
// depends on iafp_pkg, iafp_if and imu_angle_frame_parser_unit

module imu_angle_frame_parser_unit_tb;
  import iafp_pkg::*;

  // one predicted or observed result beat
  typedef struct packed {
    logic               ok;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] roll;
    logic [ANGLE_W-1:0] yaw;
  } angle_result_t;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // drain margin for the frame queue and the output register
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned FRAME_BYTES = FRAME_LAST_INDEX + 1;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  iafp_byte_if   byte_ch ();
  iafp_result_if res_ch ();

  imu_angle_frame_parser_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_in    (byte_ch),
    .result_out (res_ch)
  );

  // predictor state, mirrors the parser
  logic [7:0]         hdr_first_m;
  logic [7:0]         hdr_second_m;
  logic [INDEX_W-1:0] pos_m;
  logic [7:0]         sum_m;
  logic [7:0]         angle_m [ANGLE_BYTES];

  angle_result_t expected_angles [$];

  int unsigned cycle_count = 0;
  int          errors = 0;
  int          bytes_sent = 0;
  int          frames_checked = 0;
  int          frames_ok = 0;
  int          frames_bad = 0;

  // idle controls for sender and result sink
  bit sender_idle_en = 1'b1;
  bit sink_stall_en = 1'b1;

  // 2-unit clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // gap length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // (raw*45)>>6, raw little-endian from two bytes
  function automatic logic [ANGLE_W-1:0] scale_angle(input logic [7:0] lo, input logic [7:0] hi);
    logic [21:0] prod;
    prod = 22'({hi, lo}) * 22'd45;
    return prod[21:6];
  endfunction

  // advance the predictor by one accepted byte beat
  function automatic void parse_byte(input logic [7:0] b);
    angle_result_t r;
    if (pos_m == IDX_HEADER_FIRST) begin
      // failed header byte is simply dropped, the search stays at byte 0
      if (b != hdr_first_m) begin
        pos_m = IDX_HEADER_FIRST;
      end else begin
        sum_m = b;
        pos_m = IDX_HEADER_SECOND;
      end
    end else if (pos_m == IDX_HEADER_SECOND) begin
      // a wrong second byte is not retried as a first header byte
      if (b != hdr_second_m) begin
        pos_m = IDX_HEADER_FIRST;
      end else begin
        sum_m = sum_m + b;
        pos_m = IDX_ANGLE_FIRST;
      end
    end else if (pos_m < IDX_FRAME_LAST) begin
      if (pos_m <= IDX_ANGLE_LAST) angle_m[int'(pos_m) - int'(IDX_ANGLE_FIRST)] = b;
      sum_m = sum_m + b;
      pos_m = pos_m + INDEX_W'(1);
    end else begin
      // checksum byte closes the frame, bad sum gives zero angles
      pos_m = IDX_HEADER_FIRST;
      if (sum_m == b) begin
        r.ok = 1'b1;
        r.pitch = scale_angle(angle_m[0], angle_m[1]);
        r.roll = scale_angle(angle_m[2], angle_m[3]);
        r.yaw = scale_angle(angle_m[4], angle_m[5]);
      end else begin
        r = '0;
      end
      sum_m = '0;
      expected_angles.push_back(r);
    end
  endfunction

  // result sink: ready runs of random length, long stalls now and then
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!sink_stall_en) begin
        hold = 0;
        res_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold = hold - 1;
      end else if (res_ch.ready) begin
        res_ch.ready <= 1'b0;
        hold = pick_gap();
      end else begin
        res_ch.ready <= 1'b1;
        hold = $urandom_range(0, 15);
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result checker: every result beat against the oldest prediction
  always @(posedge clk) begin
    angle_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_angles.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual ok %0b pitch %0d roll %0d yaw %0d",
                 $time, res_ch.checksum_ok, res_ch.pitch_deg, res_ch.roll_deg, res_ch.yaw_deg);
      end else begin
        exp_r = expected_angles.pop_front();
        frames_checked++;
        if (exp_r.ok) frames_ok++;
        else frames_bad++;
        check_field("checksum_ok", int'(exp_r.ok), int'(res_ch.checksum_ok));
        check_field("pitch_deg", int'(exp_r.pitch), int'(res_ch.pitch_deg));
        check_field("roll_deg", int'(exp_r.roll), int'(res_ch.roll_deg));
        check_field("yaw_deg", int'(exp_r.yaw), int'(res_ch.yaw_deg));
      end
    end
  end

  // one byte beat, with an optional gap in front
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    parse_byte(b);
    bytes_sent++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_HEADER_FIRST) hdr_first_m = val;
    else hdr_second_m = val;
  endtask

  // payload byte with a bias toward the extremes
  function automatic logic [7:0] rand_payload();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // full frame; fill < 0 means random payload, bad_sum corrupts the checksum
  task automatic send_frame(input logic [7:0] h1, input logic [7:0] h2, input int fill,
                            input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] v;
    sum = h1 + h2;
    send_byte(h1);
    send_byte(h2);
    for (int i = 2; i < FRAME_BYTES - 1; i++) begin
      v = (fill < 0) ? rand_payload() : 8'(fill);
      sum = sum + v;
      send_byte(v);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // mostly clean frames, some checksum errors, noise and broken frames
  task automatic random_mix(input int n_bytes, input logic [7:0] h1, input logic [7:0] h2);
    int stop_at;
    int r;
    int n;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(h1, h2, -1, 1'b0);
      end else if (r < 82) begin
        send_frame(h1, h2, -1, 1'b1);
      end else if (r < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? h1 : 8'($urandom));
      end else if (r < 95) begin
        // truncated frame, the next frame's bytes land in its tail
        send_byte(h1);
        send_byte(h2);
        n = $urandom_range(0, 8);
        repeat (n) send_byte(8'($urandom));
      end else begin
        // good first header, wrong second header
        send_byte(h1);
        send_byte(h2 ^ 8'($urandom_range(1, 255)));
      end
    end
  endtask

  // header mismatches on either byte, then max-angle and bad-checksum frames
  task automatic test_directed();
    send_byte(HEADER_FIRST_RESET ^ 8'hFF);
    send_byte(HEADER_FIRST_RESET);
    // repeated first header fails as second byte and is dropped
    send_byte(HEADER_FIRST_RESET);
    send_frame(HEADER_FIRST_RESET, HEADER_SECOND_RESET, 255, 1'b0);
    send_frame(HEADER_FIRST_RESET, HEADER_SECOND_RESET, 0, 1'b1);
    settle();
  endtask

  // reset header values, random traffic with one full drain in the middle
  task automatic test_random_frames();
    random_mix(400, HEADER_FIRST_RESET, HEADER_SECOND_RESET);
    settle();
    random_mix(400, HEADER_FIRST_RESET, HEADER_SECOND_RESET);
    settle();
  endtask

  // header registers at the extremes, mixed, at random values and back at reset values
  task automatic test_header_settings();
    logic [7:0] h1s [6];
    logic [7:0] h2s [6];
    h1s = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'($urandom), HEADER_FIRST_RESET};
    h2s = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom), HEADER_SECOND_RESET};
    for (int k = 0; k < 6; k++) begin
      settle();
      write_reg(REG_HEADER_FIRST, h1s[k]);
      write_reg(REG_HEADER_SECOND, h2s[k]);
      // one setting runs back to back with no idling on either side
      sender_idle_en = (k != 1);
      sink_stall_en = (k != 1);
      random_mix(110, h1s[k], h2s[k]);
    end
    sender_idle_en = 1'b1;
    sink_stall_en = 1'b1;
    settle();
  endtask

  initial begin
    byte_ch.valid <= 1'b0;
    byte_ch.rx_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_HEADER_FIRST;
    cfg_wdata <= '0;
    rst <= 1'b1;
    hdr_first_m = HEADER_FIRST_RESET;
    hdr_second_m = HEADER_SECOND_RESET;
    pos_m = IDX_HEADER_FIRST;
    sum_m = '0;
    foreach (angle_m[i]) angle_m[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_frames();
    test_header_settings();

    $display("summary: %0d bytes sent, %0d frames checked (%0d checksum ok, %0d checksum error)",
             bytes_sent, frames_checked, frames_ok, frames_bad);
    $display("summary: reset, all-zero, all-one, mixed and random header settings exercised");
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- imu_angle_frame_parser_unit.f -----
design/iafp_pkg.sv
design/iafp_if.sv
design/iafp_front.sv
design/iafp_queue.sv
design/iafp_back.sv
design/imu_angle_frame_parser_unit.sv
test/imu_angle_frame_parser_unit_tb.sv
